// ===== hdl/klt_pkg.sv =====
// klt_pkg: shared constants, codes and types for the keymap layer translator
// no dependencies; imported by keymap_layer_translator and klt_layer_unit
package klt_pkg;

  localparam int KLT_CODE_W         = 16;
  localparam int KLT_KEY_W          = 6;
  localparam int KLT_LAYER_W        = 2;
  localparam int KLT_CFG_W          = 16;
  localparam int KLT_CFG_IDX_W      = 3;
  localparam int KLT_SLOT_W         = 4;
  localparam int KLT_CNT_W          = 8;
  localparam int KLT_NUM_KEYS       = 64;
  localparam int KLT_NUM_LAYERS     = 4;
  localparam int KLT_NUM_LAYER_KEYS = 4;
  localparam int KLT_TABLE_DEPTH    = KLT_NUM_LAYERS * KLT_NUM_KEYS;

  localparam logic [KLT_CODE_W-1:0] KC_NO   = 16'h0000;
  localparam logic [KLT_CODE_W-1:0] KC_TRNS = 16'h0001;

  typedef enum logic [0:0] {
    OP_EVENT = 1'b0,
    OP_WRITE = 1'b1
  } klt_op_t;

  typedef enum logic [KLT_CFG_IDX_W-1:0] {
    REG_LAYER_BASE   = 3'd0,
    REG_LAYER_LIMIT  = 3'd1,
    REG_CONFIG_BASE  = 3'd2,
    REG_CONFIG_LIMIT = 3'd3,
    REG_LOWER_SLOT   = 3'd4,
    REG_RAISE_SLOT   = 3'd5,
    REG_LOWER_LAYER  = 3'd6,
    REG_MISC_LAYER   = 3'd7
  } klt_reg_t;

  typedef struct packed {
    logic [KLT_CODE_W-1:0]  layer_base;
    logic [KLT_CODE_W-1:0]  layer_limit;
    logic [KLT_CODE_W-1:0]  config_base;
    logic [KLT_CODE_W-1:0]  config_limit;
    logic [1:0]             lower_slot;
    logic [1:0]             raise_slot;
    logic [KLT_LAYER_W-1:0] lower_layer;
    logic [KLT_LAYER_W-1:0] misc_layer;
  } klt_cfg_t;

  // one hold counter step requested by the lookup stage
  typedef struct packed {
    logic                  valid;
    logic                  up;
    logic [KLT_SLOT_W-1:0] slot;
  } klt_lyr_upd_t;

endpackage

// ===== hdl/keymap_layer_translator.sv =====
// keymap_layer_translator: top level; key events and keymap writes in, translated codes out
// an accepted event reads the keymap copies and pressed memory into the lookup stage, and
//   its result is registered in the output register; the lookup stage interlock stalls all
//   requests until it retires the event (the next lookup needs the active layer and pressed
//   memory this event leaves); keymap writes go one per cycle while no lookup is pending
// reset sets config to defaults and clears hold counters, active layer, stage valid flags
//   and pressed-key valid bits at once; keymap contents are not cleared, no clearing pass
// depends on klt_pkg, klt_ram, klt_layer_unit
module keymap_layer_translator
  import klt_pkg::*;
#(
  parameter int NUM_LAYER_KEYS = KLT_NUM_LAYER_KEYS
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_we,
  input  logic [KLT_CFG_IDX_W-1:0] cfg_index,
  input  logic [KLT_CFG_W-1:0]     cfg_data,
  // request channel
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic                     opcode,
  input  logic [KLT_KEY_W-1:0]     key_index,
  input  logic                     pressed,
  input  logic [KLT_LAYER_W-1:0]   table_layer,
  input  logic [KLT_CODE_W-1:0]    table_code,
  // response channel
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic [KLT_CODE_W-1:0]    out_code,
  output logic                     out_pressed
);

  localparam int TAW = $clog2(KLT_TABLE_DEPTH);
  localparam int KAW = $clog2(KLT_NUM_KEYS);

  klt_cfg_t               cfg;
  klt_lyr_upd_t           lyr_upd;
  logic [KLT_LAYER_W-1:0] active_layer;

  logic                   req_fire;
  logic                   key_ok;
  logic                   tbl_we;
  logic                   lookup_re;
  logic [TAW-1:0]         tbl_waddr;
  logic [TAW-1:0]         sel_raddr;
  logic [TAW-1:0]         base_raddr;
  logic [KLT_CODE_W-1:0]  sel_data;
  logic [KLT_CODE_W-1:0]  base_data;
  logic [KLT_CODE_W-1:0]  pmem_data;

  logic                   s1_valid;
  logic [KLT_KEY_W-1:0]   s1_key;
  logic                   s1_press;
  logic                   s1_done;

  logic [KLT_CODE_W-1:0]  code;
  logic [KLT_CODE_W-1:0]  layer_off;
  logic                   in_config;
  logic                   is_layer;
  logic                   emit;
  logic [KLT_CODE_W-1:0]  emit_code;
  logic                   pmem_we;
  logic [KLT_NUM_KEYS-1:0] pvalid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layer_base   <= '0;
      cfg.layer_limit  <= '0;
      cfg.config_base  <= '0;
      cfg.config_limit <= '0;
      cfg.lower_slot   <= 2'd0;
      cfg.raise_slot   <= 2'd1;
      cfg.lower_layer  <= 2'd1;
      cfg.misc_layer   <= 2'd2;
    end else if (cfg_we) begin
      case (klt_reg_t'(cfg_index))
        REG_LAYER_BASE:   cfg.layer_base   <= cfg_data;
        REG_LAYER_LIMIT:  cfg.layer_limit  <= cfg_data;
        REG_CONFIG_BASE:  cfg.config_base  <= cfg_data;
        REG_CONFIG_LIMIT: cfg.config_limit <= cfg_data;
        REG_LOWER_SLOT:   cfg.lower_slot   <= cfg_data[1:0];
        REG_RAISE_SLOT:   cfg.raise_slot   <= cfg_data[1:0];
        REG_LOWER_LAYER:  cfg.lower_layer  <= cfg_data[KLT_LAYER_W-1:0];
        REG_MISC_LAYER:   cfg.misc_layer   <= cfg_data[KLT_LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  // accept side: keymap writes go straight to both copies, events issue the reads
  assign req_stall  = s1_valid;
  assign req_fire   = req_valid && !req_stall;
  assign key_ok     = int'(key_index) < KLT_NUM_KEYS;
  assign tbl_we     = req_fire && key_ok && (klt_op_t'(opcode) == OP_WRITE)
                      && (int'(table_layer) < KLT_NUM_LAYERS);
  assign lookup_re  = req_fire && key_ok && (klt_op_t'(opcode) == OP_EVENT);
  assign tbl_waddr  = {table_layer, key_index};
  assign sel_raddr  = {active_layer, key_index};
  assign base_raddr = {{KLT_LAYER_W{1'b0}}, key_index};

  // two copies so the active-layer entry and the layer 0 fallback read together
  klt_ram #(.WIDTH(KLT_CODE_W), .DEPTH(KLT_TABLE_DEPTH)) u_keymap_sel (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (table_code),
    .re    (lookup_re),
    .raddr (sel_raddr),
    .rdata (sel_data)
  );

  klt_ram #(.WIDTH(KLT_CODE_W), .DEPTH(KLT_TABLE_DEPTH)) u_keymap_base (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (table_code),
    .re    (lookup_re),
    .raddr (base_raddr),
    .rdata (base_data)
  );

  klt_ram #(.WIDTH(KLT_CODE_W), .DEPTH(KLT_NUM_KEYS)) u_pressed_mem (
    .clk   (clk),
    .we    (pmem_we),
    .waddr (s1_key[KAW-1:0]),
    .wdata (code),
    .re    (lookup_re),
    .raddr (key_index[KAW-1:0]),
    .rdata (pmem_data)
  );

  // lookup stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (lookup_re) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_re) begin
      s1_key   <= key_index;
      s1_press <= pressed;
    end
  end

  assign s1_done = s1_valid && (!rsp_valid || !rsp_stall);

  always_comb begin
    code      = (sel_data == KC_TRNS) ? base_data : sel_data;
    layer_off = code - cfg.layer_base;
    in_config = (cfg.config_base <= code) && (code < cfg.config_limit);
    // only the first NUM_LAYER_KEYS codes of a wide range are layer keys
    is_layer  = !in_config && (cfg.layer_base <= code) && (code < cfg.layer_limit)
                && (int'(layer_off) < NUM_LAYER_KEYS);
    emit      = !in_config && !is_layer;
    if (s1_press) begin
      emit_code = code;
    end else begin
      emit_code = pvalid[s1_key[KAW-1:0]] ? pmem_data : KC_NO;
    end
  end

  assign pmem_we       = s1_done && emit && s1_press;
  assign lyr_upd.valid = s1_done && is_layer;
  assign lyr_upd.up    = s1_press;
  assign lyr_upd.slot  = layer_off[KLT_SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= '0;
    end else if (s1_done && emit) begin
      pvalid[s1_key[KAW-1:0]] <= s1_press;
    end
  end

  klt_layer_unit #(.NUM_LAYER_KEYS(NUM_LAYER_KEYS)) u_layer (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .upd          (lyr_upd),
    .active_layer (active_layer)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_done && emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && emit) begin
      out_code    <= emit_code;
      out_pressed <= s1_press;
    end
  end

  // a lookup in progress stays until it retires
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_done |=> s1_valid)
    else $error("lookup stage dropped before retiring");

  // an accepted event always enters the lookup stage
  a_event_enters: assert property (@(posedge clk) disable iff (rst)
    lookup_re |=> s1_valid)
    else $error("accepted key event lost");

  // a release that produced a result leaves its key with no remembered code
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    s1_done && emit && !s1_press |=> !pvalid[$past(s1_key[KAW-1:0])])
    else $error("pressed memory not cleared on release");

  // a layer key step never also produces a result
  a_no_emit_on_layer: assert property (@(posedge clk) disable iff (rst)
    lyr_upd.valid |=> rsp_valid == $past(rsp_valid && rsp_stall))
    else $error("layer key transaction produced a result");

endmodule

// ===== hdl/klt_ram.sv =====
// klt_ram: generic single-write, single-read synchronous ram with registered read
// depends on nothing; used for the keymap copies and the pressed code memory
module klt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/klt_layer_unit.sv =====
// klt_layer_unit: per layer-key hold counters and the active layer register
// depends on klt_pkg (klt_cfg_t, klt_lyr_upd_t)
module klt_layer_unit
  import klt_pkg::*;
#(
  parameter int NUM_LAYER_KEYS = KLT_NUM_LAYER_KEYS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  klt_cfg_t               cfg,
  input  klt_lyr_upd_t           upd,
  output logic [KLT_LAYER_W-1:0] active_layer
);

  logic [KLT_CNT_W-1:0]   cnt      [NUM_LAYER_KEYS];
  logic [KLT_CNT_W-1:0]   cnt_next [NUM_LAYER_KEYS];
  logic [NUM_LAYER_KEYS-1:0] held;
  logic                   lo_held;
  logic                   hi_held;
  logic [KLT_LAYER_W-1:0] active_layer_next;

  always_comb begin
    lo_held = 1'b0;
    hi_held = 1'b0;
    for (int i = 0; i < NUM_LAYER_KEYS; i++) begin
      cnt_next[i] = cnt[i];
      if (upd.valid && int'(upd.slot) == i) begin
        cnt_next[i] = upd.up ? cnt[i] + 1'b1 : cnt[i] - 1'b1;
      end
      held[i] = (cnt_next[i] != '0);
      // a slot beyond the counter count never matches and reads as not held
      if (int'(cfg.lower_slot) == i) begin
        lo_held = held[i];
      end
      if (int'(cfg.raise_slot) == i) begin
        hi_held = held[i];
      end
    end
    if (lo_held && hi_held) begin
      active_layer_next = cfg.misc_layer;
    end else if (lo_held || hi_held) begin
      active_layer_next = cfg.lower_layer;
    end else begin
      active_layer_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LAYER_KEYS; i++) begin
        cnt[i] <= '0;
      end
      active_layer <= '0;
    end else if (upd.valid) begin
      for (int i = 0; i < NUM_LAYER_KEYS; i++) begin
        cnt[i] <= cnt_next[i];
      end
      active_layer <= active_layer_next;
    end
  end

endmodule
